// File: hdl/mmc3ob_pkg.sv
// Shared types, constants and a helper function for the outer-block bank mapper.
// No dependencies; every other file of the block takes its names from here.
package mmc3ob_pkg;

  // Geometry of the cartridge ROMs, in banks.
  localparam int PRG_BANKS = 128;
  localparam int CHR_BANKS = 1024;
  localparam int BANK_W    = 10;
  localparam logic [BANK_W-1:0] PRG_TOP = BANK_W'(PRG_BANKS - 1);
  localparam logic [BANK_W-1:0] CHR_TOP = BANK_W'(CHR_BANKS - 1);

  // Command codes.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PRG   = 2'd1;
  localparam logic [1:0] CMD_CHR   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_OUTER   = 1'b0;
  localparam logic CFG_VARIANT = 1'b1;

  // Board variant codes.
  localparam logic [2:0] VAR_P4_C7   = 3'd0;
  localparam logic [2:0] VAR_P5_C7   = 3'd1;
  localparam logic [2:0] VAR_P4_C8   = 3'd2;
  localparam logic [2:0] VAR_P5_C8   = 3'd3;
  localparam logic [2:0] VAR_SPLIT   = 3'd4;

  // Register write decode.
  localparam logic [15:0] DEC_MASK   = 16'hE001;
  localparam logic [15:0] DEC_SELECT = 16'h8000;
  localparam logic [15:0] DEC_BANK   = 16'h8001;

  // Inner masks and fixed PRG banks.
  localparam logic [7:0] PRG_MASK_S = 8'h0F;
  localparam logic [7:0] PRG_MASK_L = 8'h1F;
  localparam logic [7:0] CHR_MASK_S = 8'h7F;
  localparam logic [7:0] CHR_MASK_L = 8'hFF;
  localparam logic [7:0] PRG_LAST   = 8'hFF;
  localparam logic [7:0] PRG_SECOND = 8'hFE;

  localparam logic [7:0] BANK_REG_INIT [8] =
    '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd0};

  // One accepted command as held in the input register.
  typedef struct packed {
    logic        valid;
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  // Banking state seen by the translation logic.
  typedef struct packed {
    logic [7:0]      select;
    logic [7:0][7:0] regs;
  } bank_state_t;

  // Outer merge followed by the wrap to the ROM size.
  function automatic logic [BANK_W-1:0] merge_wrap(
    input logic [1:0]        outer,
    input logic [3:0]        shift,
    input logic [7:0]        mask,
    input logic [7:0]        inner,
    input logic [BANK_W-1:0] top
  );
    logic [BANK_W-1:0] outer_sh;
    logic [BANK_W-1:0] mask_w;
    logic [BANK_W-1:0] v;
    outer_sh = BANK_W'(outer) << shift;
    mask_w   = BANK_W'(mask);
    v        = (outer_sh & ~mask_w) | (BANK_W'(inner) & mask_w);
    if (v > top) begin
      v = v & top;
    end
    return v;
  endfunction

endpackage

// File: hdl/mmc3_outer_bank_mapper.sv
// Top level of the outer-block bank mapper: input register, configuration
// registers, bank register file and translation. Depends on mmc3ob_pkg,
// mmc3ob_regs and mmc3ob_xlate.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------
//   command  | start, busy              | command, address, data
//   result   | result_valid (strobe)    | bank_number, is_chr
//   config   | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// Every lookup item passes from the input register through the
// translation logic into the result register. A new item is taken in
// every cycle, so busy is never raised. A register write updates the
// banking state as it leaves the input register, so an item accepted in
// the very next cycle already sees the new value. Reset is synchronous
// and active high; it drops any item in flight and restores the bank
// registers to their power-on values. The receiver cannot stall: each
// result is shown for exactly one cycle.
module mmc3_outer_bank_mapper (
  input  logic        clk,
  input  logic        rst,
  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  // Result channel.
  output logic        result_valid,
  output logic [9:0]  bank_number,
  output logic        is_chr,
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);

  mmc3ob_pkg::item_t       item;
  mmc3ob_pkg::bank_state_t state;
  logic [1:0]              outer_block;
  logic [2:0]              board_variant;

  // The pipeline never backs up, so both channels are always open.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Input register. Only the valid bit needs clearing on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= start && !busy;
    end
    item.command <= command;
    item.address <= address;
    item.data    <= data;
  end

  // Configuration registers: the outer block number and the board variant.
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_block   <= '0;
      board_variant <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmc3ob_pkg::CFG_OUTER:   outer_block   <= cfg_data[1:0];
        mmc3ob_pkg::CFG_VARIANT: board_variant <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bank-select byte and bank registers, written by register-write items.
  mmc3ob_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .state (state)
  );

  // Translation of PRG and CHR lookups into the result register.
  mmc3ob_xlate u_xlate (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .state         (state),
    .outer_block   (outer_block),
    .board_variant (board_variant),
    .result_valid  (result_valid),
    .bank_number   (bank_number),
    .is_chr        (is_chr)
  );

endmodule

// File: hdl/mmc3ob_regs.sv
// Bank-select byte and the eight bank registers, with the CPU write decode.
// Depends on mmc3ob_pkg.
module mmc3ob_regs (
  input  logic                    clk,
  input  logic                    rst,
  input  mmc3ob_pkg::item_t       item,
  output mmc3ob_pkg::bank_state_t state
);

  logic [7:0]  bank_select;
  logic [7:0]  bank_regs [8];
  logic [15:0] dec;
  logic        is_write;

  assign is_write = item.valid && (item.command == mmc3ob_pkg::CMD_WRITE);
  assign dec      = item.address & mmc3ob_pkg::DEC_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select <= '0;
      for (int i = 0; i < 8; i++) begin
        bank_regs[i] <= mmc3ob_pkg::BANK_REG_INIT[i];
      end
    end else if (is_write) begin
      if (dec == mmc3ob_pkg::DEC_SELECT) begin
        bank_select <= item.data;
      end else if (dec == mmc3ob_pkg::DEC_BANK) begin
        bank_regs[bank_select[2:0]] <= item.data;
      end
    end
  end

  always_comb begin
    state.select = bank_select;
    for (int i = 0; i < 8; i++) begin
      state.regs[i] = bank_regs[i];
    end
  end

endmodule

// File: hdl/mmc3ob_xlate.sv
// PRG and CHR address translation with outer merge, and the result register.
// Depends on mmc3ob_pkg.
module mmc3ob_xlate (
  input  logic                    clk,
  input  logic                    rst,
  input  mmc3ob_pkg::item_t       item,
  input  mmc3ob_pkg::bank_state_t state,
  input  logic [1:0]              outer_block,
  input  logic [2:0]              board_variant,
  output logic                    result_valid,
  output logic [9:0]              bank_number,
  output logic                    is_chr
);

  logic [1:0] prg_slot;
  logic [2:0] chr_slot;
  logic [7:0] prg_inner;
  logic [7:0] chr_inner;
  logic [7:0] chr_pair;
  logic [2:0] chr_idx;
  logic       prg_wide;
  logic       chr_wide;
  logic [9:0] prg_bank;
  logic [9:0] chr_bank;
  logic       is_prg_cmd;
  logic       is_chr_cmd;

  always_comb begin
    prg_slot = item.address[14:13];
    unique case (prg_slot)
      2'd1:    prg_inner = state.regs[7];
      2'd3:    prg_inner = mmc3ob_pkg::PRG_LAST;
      default: prg_inner = ((prg_slot == 2'd0) != state.select[6]) ? state.regs[6]
                                                                    : mmc3ob_pkg::PRG_SECOND;
    endcase

    chr_slot = item.address[12:10] ^ {state.select[7], 2'b00};
    chr_pair = state.regs[{2'b00, chr_slot[1]}];
    chr_idx  = chr_slot - 3'd2;
    if (!chr_slot[2]) begin
      chr_inner = {chr_pair[7:1], chr_slot[0]};
    end else begin
      chr_inner = state.regs[chr_idx];
    end

    prg_wide = (board_variant == mmc3ob_pkg::VAR_P5_C7) ||
               (board_variant == mmc3ob_pkg::VAR_P5_C8) ||
               ((board_variant == mmc3ob_pkg::VAR_SPLIT) && (outer_block == 2'd0));
    chr_wide = (board_variant == mmc3ob_pkg::VAR_P4_C8) ||
               (board_variant == mmc3ob_pkg::VAR_P5_C8);

    prg_bank = mmc3ob_pkg::merge_wrap(outer_block, prg_wide ? 4'd5 : 4'd4,
                 prg_wide ? mmc3ob_pkg::PRG_MASK_L : mmc3ob_pkg::PRG_MASK_S,
                 prg_inner, mmc3ob_pkg::PRG_TOP);
    chr_bank = mmc3ob_pkg::merge_wrap(outer_block, chr_wide ? 4'd8 : 4'd7,
                 chr_wide ? mmc3ob_pkg::CHR_MASK_L : mmc3ob_pkg::CHR_MASK_S,
                 chr_inner, mmc3ob_pkg::CHR_TOP);
  end

  assign is_prg_cmd = item.valid && (item.command == mmc3ob_pkg::CMD_PRG);
  assign is_chr_cmd = item.valid && (item.command == mmc3ob_pkg::CMD_CHR);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= is_prg_cmd || is_chr_cmd;
    end
    bank_number <= is_chr_cmd ? chr_bank : prg_bank;
    is_chr      <= is_chr_cmd;
  end

endmodule

// File: hdl/mmc3ob_checker.sv
// Port-level checks on the outer-block bank mapper, bound to its top level.
// Depends on mmc3ob_pkg and mmc3_outer_bank_mapper.
module mmc3ob_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] command,
  input logic       result_valid,
  input logic [9:0] bank_number,
  input logic       is_chr
);

  logic lookup_in;

  assign lookup_in = start && !busy &&
                     ((command == mmc3ob_pkg::CMD_PRG) || (command == mmc3ob_pkg::CMD_CHR));

  // A lookup item always gives a result, through the input register and the result register.
  a_lookup_answers: assert property (@(posedge clk) disable iff (rst)
    lookup_in |=> ##1 result_valid)
    else $error("lookup item gave no result");

  // A result is only ever caused by a lookup item that passed the input register and the result register.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(lookup_in, 2))
    else $error("result without a lookup item");

  // The result kind follows the command that caused it.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (is_chr == $past(command == mmc3ob_pkg::CMD_CHR, 2)))
    else $error("result kind does not match command");

  // PRG banks stay inside the PRG ROM.
  a_prg_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_chr) |-> (bank_number <= mmc3ob_pkg::PRG_TOP))
    else $error("PRG bank beyond ROM size");

endmodule

bind mmc3_outer_bank_mapper mmc3ob_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .command      (command),
  .result_valid (result_valid),
  .bank_number  (bank_number),
  .is_chr       (is_chr)
);
